[hdl/fsp_pkg.sv]
package fsp_pkg;

    // Characters that steer the parser
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_LO_D   = 8'h64;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_G   = 8'h67;
    localparam logic [7:0] CH_LO_H   = 8'h68;
    localparam logic [7:0] CH_LO_I   = 8'h69;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_O   = 8'h6F;
    localparam logic [7:0] CH_LO_P   = 8'h70;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // Number limits
    localparam int unsigned NUM_DIGITS_MAX_DEF = 10;
    localparam int          CNT_W              = 5;
    localparam logic [CNT_W-1:0] CNT_TOP       = 5'd31;
    localparam logic [30:0] INT_TOP            = 31'h7FFF_FFFF;
    localparam logic [31:0] PREC_NONE          = 32'hFFFF_FFFF;
    localparam logic [31:0] PREC_F_DEFAULT     = 32'd6;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;

    // Flag bit positions
    localparam int FB_MINUS = 0;
    localparam int FB_PLUS  = 1;
    localparam int FB_HASH  = 2;
    localparam int FB_ZERO  = 3;
    localparam int FB_SPACE = 4;

    // Length modifier codes
    typedef enum logic [2:0] {
        LEN_NONE = 3'd0,
        LEN_HH   = 3'd1,
        LEN_H    = 3'd2,
        LEN_L    = 3'd3,
        LEN_LL   = 3'd4,
        LEN_BIG_L = 3'd5
    } t_len;

    // Outcome codes
    typedef enum logic [2:0] {
        OUT_SPEC    = 3'd0,
        OUT_PERCENT = 3'd1,
        OUT_END     = 3'd2,
        OUT_UNKNOWN = 3'd3,
        OUT_OTHER   = 3'd4
    } t_outcome;

    // Parser phases, one-hot
    typedef enum logic [7:0] {
        PH_FLAGS = 8'b0000_0001,
        PH_WDIG  = 8'b0000_0010,
        PH_WSTAR = 8'b0000_0100,
        PH_DOT   = 8'b0000_1000,
        PH_PDIG  = 8'b0001_0000,
        PH_MOD   = 8'b0010_0000,
        PH_H1    = 8'b0100_0000,
        PH_L1    = 8'b1000_0000
    } t_phase;

endpackage

[hdl/format_spec_parser.sv]
// Path: a character enters the input register; its result (if any) then enters
//   the result register, which drives o_m_tvalid. Parsing is one pass of logic.
// Throughput: one character per cycle unless an untaken result stalls the input.
// Reset: i_rst_n is synchronous, active low; it returns the parser to the flags
//   phase with all fields cleared and empties both register stages.
module format_spec_parser #(
    parameter int unsigned NUM_DIGITS_MAX = fsp_pkg::NUM_DIGITS_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] ch, [39:8] star_arg
    input  logic [fsp_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [2:0] outcome, [10:3] spec_char, [11] left_align, [12] show_plus,
    // [13] alt_form, [14] zero_pad, [15] space_sign, [46:16] field_width,
    // [78:47] prec_value, [81:79] length_mod, [82] num_overflow, [87:83] zero
    output logic [fsp_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // Input stage
    logic        r_s1_valid;
    logic [7:0]  r_ch;
    logic [31:0] r_arg;
    logic        s1_adv;

    // Parser state
    fsp_pkg::t_phase               r_phase, n_phase;
    logic [4:0]                    r_flags, n_flags;
    logic [30:0]                   r_width, n_width;
    logic [31:0]                   r_prec, n_prec;
    logic [2:0]                    r_mod, n_mod;
    logic                          r_ovf, n_ovf;
    logic [fsp_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    // Output stage
    logic                          r_out_valid;
    logic [fsp_pkg::OUT_DATA_W-1:0] r_out_data;

    // Digit accumulate
    logic                          w_is_digit;
    logic [3:0]                    w_digit;
    logic                          w_use_prec;
    logic [30:0]                   w_acc;
    logic                          w_acc_nz;
    logic [34:0]                   w_mul;
    logic [fsp_pkg::CNT_W-1:0]     w_cnt_next;
    logic                          w_dig_ovf;
    logic [30:0]                   w_dig_val;

    // Star width
    logic [31:0]                   w_mag;

    // Modifier or terminate
    logic                          w_mt_h, w_mt_l, w_mt_big_l;
    logic                          w_term;

    // Finish
    fsp_pkg::t_outcome             w_outcome;
    logic [7:0]                    w_spec;
    logic [4:0]                    w_fb;
    logic [31:0]                   w_prec_out;
    logic                          w_is_spec, w_is_letter, w_prec_zero_clr, w_csp;

    // Handshake
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_s1_valid || s1_adv;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Shared multiply-by-ten for width or precision digits
    assign w_is_digit = (r_ch >= fsp_pkg::CH_0) && (r_ch <= fsp_pkg::CH_9);
    assign w_digit    = r_ch[3:0];  // low nibble of an ASCII digit is its value
    assign w_use_prec = (r_phase == fsp_pkg::PH_DOT) || (r_phase == fsp_pkg::PH_PDIG);
    assign w_acc      = w_use_prec ? r_prec[30:0] : r_width;
    assign w_acc_nz   = w_use_prec ? (r_prec != 32'd0) : (r_width != 31'd0);
    assign w_mul      = {1'b0, w_acc, 3'b000} + {3'b000, w_acc, 1'b0} + {31'd0, w_digit};
    assign w_cnt_next = ((w_acc_nz || w_digit != 4'd0) && r_cnt < fsp_pkg::CNT_TOP)
                        ? r_cnt + 1'b1 : r_cnt;
    assign w_dig_ovf  = (32'(w_cnt_next) > NUM_DIGITS_MAX)
                        || (w_mul > {4'd0, fsp_pkg::INT_TOP});
    assign w_dig_val  = w_dig_ovf ? fsp_pkg::INT_TOP : w_mul[30:0];

    // Magnitude of a negative star argument
    assign w_mag = ~r_arg + 32'd1;

    // Modifier acceptance against the current modifier
    assign w_mt_h     = (r_ch == fsp_pkg::CH_LO_H) && (r_mod == fsp_pkg::LEN_NONE);
    assign w_mt_l     = (r_ch == fsp_pkg::CH_LO_L) && (r_mod <= fsp_pkg::LEN_H);
    assign w_mt_big_l = (r_ch == fsp_pkg::CH_UP_L) && (r_mod <= fsp_pkg::LEN_LL);

    // Phase step
    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_width = r_width;
        n_prec  = r_prec;
        n_mod   = r_mod;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        w_term  = 1'b0;
        unique case (r_phase)
            fsp_pkg::PH_FLAGS: begin
                priority if (r_ch == fsp_pkg::CH_MINUS) begin
                    n_flags[fsp_pkg::FB_MINUS] = 1'b1;
                end else if (r_ch == fsp_pkg::CH_PLUS) begin
                    n_flags[fsp_pkg::FB_PLUS] = 1'b1;
                end else if (r_ch == fsp_pkg::CH_HASH) begin
                    n_flags[fsp_pkg::FB_HASH] = 1'b1;
                end else if (r_ch == fsp_pkg::CH_0) begin
                    n_flags[fsp_pkg::FB_ZERO] = 1'b1;
                end else if (r_ch == fsp_pkg::CH_SPACE) begin
                    n_flags[fsp_pkg::FB_SPACE] = 1'b1;
                end else if (r_ch == fsp_pkg::CH_APOS) begin
                    n_phase = r_phase;
                end else if (r_ch == fsp_pkg::CH_STAR) begin
                    if (r_arg[31]) begin
                        n_flags[fsp_pkg::FB_MINUS] = 1'b1;
                        n_width = w_mag[31] ? fsp_pkg::INT_TOP : w_mag[30:0];
                        if (w_mag[31]) begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_width = r_arg[30:0];
                    end
                    n_phase = fsp_pkg::PH_WSTAR;
                end else if (w_is_digit) begin
                    n_width = w_dig_val;
                    n_cnt   = w_cnt_next;
                    n_ovf   = r_ovf | w_dig_ovf;
                    n_phase = fsp_pkg::PH_WDIG;
                end else if (r_ch == fsp_pkg::CH_DOT) begin
                    n_prec  = 32'd0;
                    n_cnt   = '0;
                    n_phase = fsp_pkg::PH_DOT;
                end else begin
                    w_term = 1'b1;
                end
            end
            fsp_pkg::PH_WDIG: begin
                priority if (w_is_digit) begin
                    n_width = w_dig_val;
                    n_cnt   = w_cnt_next;
                    n_ovf   = r_ovf | w_dig_ovf;
                end else if (r_ch == fsp_pkg::CH_DOT) begin
                    n_prec  = 32'd0;
                    n_cnt   = '0;
                    n_phase = fsp_pkg::PH_DOT;
                end else begin
                    w_term = 1'b1;
                end
            end
            fsp_pkg::PH_WSTAR: begin
                if (r_ch == fsp_pkg::CH_DOT) begin
                    n_prec  = 32'd0;
                    n_cnt   = '0;
                    n_phase = fsp_pkg::PH_DOT;
                end else begin
                    w_term = 1'b1;
                end
            end
            fsp_pkg::PH_DOT: begin
                priority if (r_ch == fsp_pkg::CH_STAR) begin
                    n_prec  = r_arg[31] ? fsp_pkg::PREC_NONE : r_arg;
                    n_phase = fsp_pkg::PH_MOD;
                end else if (w_is_digit) begin
                    n_prec  = {1'b0, w_dig_val};
                    n_cnt   = w_cnt_next;
                    n_ovf   = r_ovf | w_dig_ovf;
                    n_phase = fsp_pkg::PH_PDIG;
                end else begin
                    w_term = 1'b1;
                end
            end
            fsp_pkg::PH_PDIG: begin
                if (w_is_digit) begin
                    n_prec = {1'b0, w_dig_val};
                    n_cnt  = w_cnt_next;
                    n_ovf  = r_ovf | w_dig_ovf;
                end else begin
                    w_term = 1'b1;
                end
            end
            fsp_pkg::PH_H1: begin
                n_phase = fsp_pkg::PH_MOD;
                if (r_ch == fsp_pkg::CH_LO_H) begin
                    n_mod = fsp_pkg::LEN_HH;
                end else begin
                    w_term = 1'b1;
                end
            end
            fsp_pkg::PH_L1: begin
                n_phase = fsp_pkg::PH_MOD;
                if (r_ch == fsp_pkg::CH_LO_L) begin
                    n_mod = fsp_pkg::LEN_LL;
                end else begin
                    w_term = 1'b1;
                end
            end
            default: begin
                w_term = 1'b1;
            end
        endcase

        // A terminating candidate may still be a modifier letter
        if (w_term) begin
            priority if (w_mt_h) begin
                w_term  = 1'b0;
                n_mod   = fsp_pkg::LEN_H;
                n_phase = fsp_pkg::PH_H1;
            end else if (w_mt_l) begin
                w_term  = 1'b0;
                n_mod   = fsp_pkg::LEN_L;
                n_phase = fsp_pkg::PH_L1;
            end else if (w_mt_big_l) begin
                w_term  = 1'b0;
                n_mod   = fsp_pkg::LEN_BIG_L;
                n_phase = fsp_pkg::PH_MOD;
            end else begin
                w_term  = 1'b1;
            end
        end

        // Clear everything after the terminator
        if (w_term) begin
            n_phase = fsp_pkg::PH_FLAGS;
            n_flags = '0;
            n_width = '0;
            n_prec  = fsp_pkg::PREC_NONE;
            n_mod   = fsp_pkg::LEN_NONE;
            n_ovf   = 1'b0;
            n_cnt   = '0;
        end
    end

    // Classify the terminator and apply the overrides
    always_comb begin
        unique case (r_ch)
            fsp_pkg::CH_LO_D, fsp_pkg::CH_LO_I, fsp_pkg::CH_LO_X, fsp_pkg::CH_UP_X,
            fsp_pkg::CH_LO_O, fsp_pkg::CH_LO_C, fsp_pkg::CH_LO_P, fsp_pkg::CH_LO_F,
            fsp_pkg::CH_LO_S, fsp_pkg::CH_LO_U, fsp_pkg::CH_LO_B, fsp_pkg::CH_LO_N,
            fsp_pkg::CH_LO_E, fsp_pkg::CH_UP_E, fsp_pkg::CH_LO_G: w_is_spec = 1'b1;
            default: w_is_spec = 1'b0;
        endcase
        w_is_letter = ((r_ch >= fsp_pkg::CH_LO_A) && (r_ch <= fsp_pkg::CH_LO_Z))
                      || ((r_ch >= fsp_pkg::CH_UP_A) && (r_ch <= fsp_pkg::CH_UP_Z));
        w_spec = fsp_pkg::CH_BANG;
        priority if (w_is_spec) begin
            w_outcome = fsp_pkg::OUT_SPEC;
            w_spec    = r_ch;
        end else if (w_is_letter) begin
            w_outcome = fsp_pkg::OUT_UNKNOWN;
        end else if (r_ch == fsp_pkg::CH_PCT) begin
            w_outcome = fsp_pkg::OUT_PERCENT;
        end else if (r_ch == fsp_pkg::CH_NUL) begin
            w_outcome = fsp_pkg::OUT_END;
        end else begin
            w_outcome = fsp_pkg::OUT_OTHER;
        end

        w_prec_zero_clr = (r_prec != fsp_pkg::PREC_NONE)
            && ((w_spec == fsp_pkg::CH_LO_D) || (w_spec == fsp_pkg::CH_LO_I)
                || (w_spec == fsp_pkg::CH_LO_X) || (w_spec == fsp_pkg::CH_UP_X)
                || (w_spec == fsp_pkg::CH_LO_O) || (w_spec == fsp_pkg::CH_LO_F)
                || (w_spec == fsp_pkg::CH_LO_U));
        w_csp = (w_spec == fsp_pkg::CH_LO_C) || (w_spec == fsp_pkg::CH_LO_S)
                || (w_spec == fsp_pkg::CH_LO_P);

        w_fb       = r_flags;
        w_prec_out = r_prec;
        if ((w_outcome == fsp_pkg::OUT_SPEC) || (w_outcome == fsp_pkg::OUT_OTHER)) begin
            if (r_flags[fsp_pkg::FB_PLUS]) begin
                w_fb[fsp_pkg::FB_SPACE] = 1'b0;
            end
            if (r_flags[fsp_pkg::FB_MINUS] || w_prec_zero_clr || w_csp) begin
                w_fb[fsp_pkg::FB_ZERO] = 1'b0;
            end
            if ((w_spec == fsp_pkg::CH_LO_F) && (r_prec == fsp_pkg::PREC_NONE)) begin
                w_prec_out = fsp_pkg::PREC_F_DEFAULT;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_ch  <= i_s_tdata[7:0];
            r_arg <= i_s_tdata[39:8];
        end
    end

    // Parser state, advanced once per processed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fsp_pkg::PH_FLAGS;
            r_flags <= '0;
            r_width <= '0;
            r_prec  <= fsp_pkg::PREC_NONE;
            r_mod   <= fsp_pkg::LEN_NONE;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
        end else if (s1_adv) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_width <= n_width;
            r_prec  <= n_prec;
            r_mod   <= n_mod;
            r_ovf   <= n_ovf;
            r_cnt   <= n_cnt;
        end
    end

    // Result register: load on a terminator, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && w_term) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv && w_term) begin
            r_out_data <= {5'd0, r_ovf, r_mod, w_prec_out, r_width,
                           w_fb[fsp_pkg::FB_SPACE], w_fb[fsp_pkg::FB_ZERO],
                           w_fb[fsp_pkg::FB_HASH], w_fb[fsp_pkg::FB_PLUS],
                           w_fb[fsp_pkg::FB_MINUS], w_spec, w_outcome};
        end
    end

    // A terminator always leaves the parser back in the flags phase
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && w_term |=> r_phase == fsp_pkg::PH_FLAGS && r_prec == fsp_pkg::PREC_NONE)
        else $error("parser state not cleared after terminator");

    // An f specifier never reports an absent precision
    a_f_prec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] == fsp_pkg::OUT_SPEC && o_m_tdata[10:3] == fsp_pkg::CH_LO_F
        |-> o_m_tdata[78:47] != fsp_pkg::PREC_NONE)
        else $error("f specifier without precision");

    // Numbers saturated by digit overflow must carry the overflow mark
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && w_is_digit && w_dig_ovf && (w_use_prec || r_phase == fsp_pkg::PH_FLAGS
        || r_phase == fsp_pkg::PH_WDIG) |=> r_ovf)
        else $error("digit overflow not recorded");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int DIGITS_MAX     = fsp_pkg::NUM_DIGITS_MAX_DEF;
    localparam int RANDOM_CHARS   = 1500;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 8;

    // One character on the input stream, with the star argument beside it
    typedef struct {
        logic [7:0]  ch;
        logic [31:0] arg;
        bit          drain;   // hold this character until every result has come
    } t_char_item;

    // One parsed conversion specification
    typedef struct {
        fsp_pkg::t_outcome outcome;
        logic [7:0]        spec;
        logic [4:0]        flags;
        logic [30:0]       width;
        logic [31:0]       prec;
        fsp_pkg::t_len     lmod;
        logic              ovf;
    } t_spec_fields;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    // [7:0] ch, [39:8] star_arg
    logic [fsp_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    // [2:0] outcome, [10:3] spec_char, [15:11] flags, [46:16] field_width,
    // [78:47] prec_value, [81:79] length_mod, [82] num_overflow
    logic [fsp_pkg::OUT_DATA_W-1:0] o_m_tdata;

    t_char_item   char_queue[$];
    t_spec_fields due_specs[$];

    int errors = 0;
    int chars_sent = 0;
    int specs_seen = 0;
    int outcome_count[5] = '{0, 0, 0, 0, 0};
    int idle_cycles = 0;

    // Parser state of the predictor
    fsp_pkg::t_phase ph;
    logic [4:0]      fb;
    logic [31:0]     wacc;
    logic [31:0]     pacc;
    fsp_pkg::t_len   lmod;
    logic            ovf;
    logic [4:0]      ndig;

    format_spec_parser DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        ph   = fsp_pkg::PH_FLAGS;
        fb   = '0;
        wacc = '0;
        pacc = fsp_pkg::PREC_NONE;
        lmod = fsp_pkg::LEN_NONE;
        ovf  = 1'b0;
        ndig = '0;
    endfunction

    // Accumulate one decimal digit, saturating on too many digits or too large a value
    function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [3:0] d);
        logic [63:0] v;
        v = {33'b0, acc[30:0]} * 64'd10 + 64'(d);
        if ((acc != 0 || d != 0) && ndig < 5'd31)
            ndig = ndig + 5'd1;
        if (ndig > DIGITS_MAX || v > 64'(fsp_pkg::INT_TOP)) begin
            ovf = 1'b1;
            return {1'b0, fsp_pkg::INT_TOP};
        end
        return v[31:0];
    endfunction

    function automatic bit is_spec_letter(input logic [7:0] c);
        case (c)
            fsp_pkg::CH_LO_D, fsp_pkg::CH_LO_I, fsp_pkg::CH_LO_X, fsp_pkg::CH_UP_X,
            fsp_pkg::CH_LO_O, fsp_pkg::CH_LO_C, fsp_pkg::CH_LO_P, fsp_pkg::CH_LO_F,
            fsp_pkg::CH_LO_S, fsp_pkg::CH_LO_U, fsp_pkg::CH_LO_B, fsp_pkg::CH_LO_N,
            fsp_pkg::CH_LO_E, fsp_pkg::CH_UP_E, fsp_pkg::CH_LO_G: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Classify the terminating character, apply the overrides, then clear the state
    function automatic t_spec_fields close_spec(input logic [7:0] c);
        t_spec_fields r;
        logic [4:0]   f;
        logic [31:0]  p;
        f = fb;
        p = pacc;
        r.spec = fsp_pkg::CH_BANG;
        if (is_spec_letter(c)) begin
            r.outcome = fsp_pkg::OUT_SPEC;
            r.spec = c;
        end else if ((c >= fsp_pkg::CH_UP_A && c <= fsp_pkg::CH_UP_Z)
                     || (c >= fsp_pkg::CH_LO_A && c <= fsp_pkg::CH_LO_Z)) begin
            r.outcome = fsp_pkg::OUT_UNKNOWN;
        end else if (c == fsp_pkg::CH_PCT) begin
            r.outcome = fsp_pkg::OUT_PERCENT;
        end else if (c == fsp_pkg::CH_NUL) begin
            r.outcome = fsp_pkg::OUT_END;
        end else begin
            r.outcome = fsp_pkg::OUT_OTHER;
        end

        if (r.outcome == fsp_pkg::OUT_SPEC || r.outcome == fsp_pkg::OUT_OTHER) begin
            if (f[fsp_pkg::FB_SPACE] && f[fsp_pkg::FB_PLUS])
                f[fsp_pkg::FB_SPACE] = 1'b0;
            if (f[fsp_pkg::FB_MINUS] && f[fsp_pkg::FB_ZERO])
                f[fsp_pkg::FB_ZERO] = 1'b0;
            if (p != fsp_pkg::PREC_NONE && (r.spec == fsp_pkg::CH_LO_D
                || r.spec == fsp_pkg::CH_LO_I || r.spec == fsp_pkg::CH_LO_X
                || r.spec == fsp_pkg::CH_UP_X || r.spec == fsp_pkg::CH_LO_O
                || r.spec == fsp_pkg::CH_LO_F || r.spec == fsp_pkg::CH_LO_U))
                f[fsp_pkg::FB_ZERO] = 1'b0;
            if (r.spec == fsp_pkg::CH_LO_C || r.spec == fsp_pkg::CH_LO_S
                || r.spec == fsp_pkg::CH_LO_P)
                f[fsp_pkg::FB_ZERO] = 1'b0;
            if (r.spec == fsp_pkg::CH_LO_F && p == fsp_pkg::PREC_NONE)
                p = fsp_pkg::PREC_F_DEFAULT;
        end

        r.flags = f;
        r.width = wacc[30:0];
        r.prec  = p;
        r.lmod  = lmod;
        r.ovf   = ovf;
        clear_parser();
        return r;
    endfunction

    // Length modifiers, or else the end of the specification
    function automatic bit modifier_or_close(input logic [7:0] c, output t_spec_fields r);
        if (c == fsp_pkg::CH_LO_H && lmod == fsp_pkg::LEN_NONE) begin
            lmod = fsp_pkg::LEN_H;
            ph = fsp_pkg::PH_H1;
            return 1'b0;
        end
        if (c == fsp_pkg::CH_LO_L && lmod <= fsp_pkg::LEN_H) begin
            lmod = fsp_pkg::LEN_L;
            ph = fsp_pkg::PH_L1;
            return 1'b0;
        end
        if (c == fsp_pkg::CH_UP_L && lmod <= fsp_pkg::LEN_LL) begin
            lmod = fsp_pkg::LEN_BIG_L;
            ph = fsp_pkg::PH_MOD;
            return 1'b0;
        end
        r = close_spec(c);
        return 1'b1;
    endfunction

    function automatic void open_precision();
        pacc = '0;
        ndig = '0;
        ph = fsp_pkg::PH_DOT;
    endfunction

    // Advance the parser by one character; returns 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, input logic [31:0] arg,
                                      output t_spec_fields r);
        bit          done;
        bit          digit;
        logic [31:0] mag;
        done = 1'b0;
        digit = (c >= fsp_pkg::CH_0 && c <= fsp_pkg::CH_9);
        case (ph)
            fsp_pkg::PH_FLAGS: begin
                if (c == fsp_pkg::CH_MINUS) fb[fsp_pkg::FB_MINUS] = 1'b1;
                else if (c == fsp_pkg::CH_PLUS) fb[fsp_pkg::FB_PLUS] = 1'b1;
                else if (c == fsp_pkg::CH_HASH) fb[fsp_pkg::FB_HASH] = 1'b1;
                else if (c == fsp_pkg::CH_0) fb[fsp_pkg::FB_ZERO] = 1'b1;
                else if (c == fsp_pkg::CH_SPACE) fb[fsp_pkg::FB_SPACE] = 1'b1;
                else if (c == fsp_pkg::CH_APOS) ;
                else if (c == fsp_pkg::CH_STAR) begin
                    if (arg[31]) begin
                        mag = ~arg + 32'd1;
                        fb[fsp_pkg::FB_MINUS] = 1'b1;
                        if (mag > {1'b0, fsp_pkg::INT_TOP}) begin
                            mag = {1'b0, fsp_pkg::INT_TOP};
                            ovf = 1'b1;
                        end
                        wacc = mag;
                    end else begin
                        wacc = arg;
                    end
                    ph = fsp_pkg::PH_WSTAR;
                end else if (digit) begin
                    wacc = add_digit(wacc, 4'(c - fsp_pkg::CH_0));
                    ph = fsp_pkg::PH_WDIG;
                end else if (c == fsp_pkg::CH_DOT) open_precision();
                else done = modifier_or_close(c, r);
            end
            fsp_pkg::PH_WDIG: begin
                if (digit) wacc = add_digit(wacc, 4'(c - fsp_pkg::CH_0));
                else if (c == fsp_pkg::CH_DOT) open_precision();
                else done = modifier_or_close(c, r);
            end
            fsp_pkg::PH_WSTAR: begin
                if (c == fsp_pkg::CH_DOT) open_precision();
                else done = modifier_or_close(c, r);
            end
            fsp_pkg::PH_DOT: begin
                if (c == fsp_pkg::CH_STAR) begin
                    pacc = arg[31] ? fsp_pkg::PREC_NONE : arg;
                    ph = fsp_pkg::PH_MOD;
                end else if (digit) begin
                    pacc = add_digit(pacc, 4'(c - fsp_pkg::CH_0));
                    ph = fsp_pkg::PH_PDIG;
                end else done = modifier_or_close(c, r);
            end
            fsp_pkg::PH_PDIG: begin
                if (digit) pacc = add_digit(pacc, 4'(c - fsp_pkg::CH_0));
                else done = modifier_or_close(c, r);
            end
            fsp_pkg::PH_H1: begin
                ph = fsp_pkg::PH_MOD;
                if (c == fsp_pkg::CH_LO_H) lmod = fsp_pkg::LEN_HH;
                else done = modifier_or_close(c, r);
            end
            fsp_pkg::PH_L1: begin
                ph = fsp_pkg::PH_MOD;
                if (c == fsp_pkg::CH_LO_L) lmod = fsp_pkg::LEN_LL;
                else done = modifier_or_close(c, r);
            end
            default: done = modifier_or_close(c, r);
        endcase
        return done;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_char(input logic [7:0] c);
        t_char_item it;
        it.ch = c;
        it.arg = $urandom;
        it.drain = 1'b0;
        char_queue.push_back(it);
    endtask

    task automatic add_star(input logic [31:0] a);
        t_char_item it;
        it.ch = fsp_pkg::CH_STAR;
        it.arg = a;
        it.drain = 1'b0;
        char_queue.push_back(it);
    endtask

    function automatic logic [7:0] pick_flag();
        case ($urandom_range(0, 5))
            0: return fsp_pkg::CH_MINUS;
            1: return fsp_pkg::CH_PLUS;
            2: return fsp_pkg::CH_HASH;
            3: return fsp_pkg::CH_0;
            4: return fsp_pkg::CH_SPACE;
            default: return fsp_pkg::CH_APOS;
        endcase
    endfunction

    function automatic logic [7:0] pick_spec_letter();
        case ($urandom_range(0, 14))
            0: return fsp_pkg::CH_LO_D;
            1: return fsp_pkg::CH_LO_I;
            2: return fsp_pkg::CH_LO_X;
            3: return fsp_pkg::CH_UP_X;
            4: return fsp_pkg::CH_LO_O;
            5: return fsp_pkg::CH_LO_C;
            6: return fsp_pkg::CH_LO_P;
            7: return fsp_pkg::CH_LO_F;
            8: return fsp_pkg::CH_LO_S;
            9: return fsp_pkg::CH_LO_U;
            10: return fsp_pkg::CH_LO_B;
            11: return fsp_pkg::CH_LO_N;
            12: return fsp_pkg::CH_LO_E;
            13: return fsp_pkg::CH_UP_E;
            default: return fsp_pkg::CH_LO_G;
        endcase
    endfunction

    function automatic logic [31:0] pick_star_arg();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'($urandom_range(0, 40));
            5: return -32'($urandom_range(1, 40));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_digits(input int n);
        repeat (n) add_char(fsp_pkg::CH_0 + 8'($urandom_range(0, 9)));
    endtask

    // Mostly well-formed specifications with random content, the rest noise
    task automatic add_random_spec(input bit pause_first);
        int first;
        first = char_queue.size();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 1) == 0)
                    add_char(8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 1) == 0)
                    add_char(pick_flag());
                else
                    add_char($urandom_range(0, 1) ? fsp_pkg::CH_STAR : fsp_pkg::CH_DOT);
            end
        end else begin
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0)
                add_char(pick_flag());

            // width
            case ($urandom_range(0, 3))
                1: begin
                    add_char(fsp_pkg::CH_0 + 8'($urandom_range(1, 9)));
                    add_digits($urandom_range(0, 9) == 0 ? $urandom_range(8, 13)
                                                         : $urandom_range(0, 3));
                end
                2: add_star(pick_star_arg());
                default: ;
            endcase

            // precision
            case ($urandom_range(0, 4))
                1: add_char(fsp_pkg::CH_DOT);
                2: begin
                    add_char(fsp_pkg::CH_DOT);
                    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0)
                        add_char(fsp_pkg::CH_0);
                    add_digits($urandom_range(0, 9) == 0 ? $urandom_range(9, 13)
                                                         : $urandom_range(1, 3));
                end
                3: begin
                    add_char(fsp_pkg::CH_DOT);
                    add_star(pick_star_arg());
                end
                default: ;
            endcase

            // length modifiers, sometimes one too many
            case ($urandom_range(0, 11))
                1: add_char(fsp_pkg::CH_LO_H);
                2: begin add_char(fsp_pkg::CH_LO_H); add_char(fsp_pkg::CH_LO_H); end
                3: add_char(fsp_pkg::CH_LO_L);
                4: begin add_char(fsp_pkg::CH_LO_L); add_char(fsp_pkg::CH_LO_L); end
                5: add_char(fsp_pkg::CH_UP_L);
                6: begin add_char(fsp_pkg::CH_LO_H); add_char(fsp_pkg::CH_LO_L); end
                7: begin
                    add_char(fsp_pkg::CH_LO_H); add_char(fsp_pkg::CH_LO_H);
                    add_char(fsp_pkg::CH_UP_L);
                end
                8: begin
                    add_char(fsp_pkg::CH_LO_L); add_char(fsp_pkg::CH_LO_L);
                    add_char(fsp_pkg::CH_UP_L);
                end
                9: begin
                    add_char(fsp_pkg::CH_LO_H); add_char(fsp_pkg::CH_LO_H);
                    add_char(fsp_pkg::CH_LO_H);
                end
                default: ;
            endcase

            // terminator
            case ($urandom_range(0, 15))
                12: add_char(fsp_pkg::CH_PCT);
                13: add_char(fsp_pkg::CH_NUL);
                14: add_char($urandom_range(0, 1)
                             ? fsp_pkg::CH_UP_A + 8'($urandom_range(0, 25))
                             : fsp_pkg::CH_LO_A + 8'($urandom_range(0, 25)));
                15: add_char(8'($urandom_range(0, 255)));
                default: add_char(pick_spec_letter());
            endcase
        end
        if (char_queue.size() > first && (pause_first || $urandom_range(0, 59) == 0))
            char_queue[first].drain = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts with random gaps; predict on every transfer
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive
        t_spec_fields r;
        t_char_item   nxt;
        logic         nv;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                chars_sent++;
                if (parse_char(i_s_tdata[7:0], i_s_tdata[39:8], r))
                    due_specs.push_back(r);
            end
            // hold the current character until it is taken
            if (!(i_s_tvalid && !o_s_tready)) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (char_queue.size() != 0 &&
                             (!char_queue[0].drain || due_specs.size() == 0)) begin
                    nxt = char_queue.pop_front();
                    nv = 1'b1;
                    i_s_tdata <= {nxt.arg, nxt.ch};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                i_s_tvalid <= nv;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern
    // ------------------------------------------------------------------
    t_rx_mode rx_mode = RX_OPEN;
    int rx_left = 0;

    always @(posedge i_clk) begin : sink_ready
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(4, 40);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_tready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_spec_fields want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, due_specs.size());
                $display("tb: done, errors");
                $finish;
            end

            if (o_m_tvalid && i_m_tready) begin
                if (due_specs.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual %0h", $time, o_m_tdata);
                end else begin
                    want = due_specs.pop_front();
                    specs_seen++;
                    if (want.outcome <= fsp_pkg::OUT_OTHER)
                        outcome_count[want.outcome]++;
                    check_field("outcome", 32'(want.outcome), 32'(o_m_tdata[2:0]));
                    check_field("spec_char", 32'(want.spec), 32'(o_m_tdata[10:3]));
                    check_field("left_align", 32'(want.flags[fsp_pkg::FB_MINUS]),
                                32'(o_m_tdata[11]));
                    check_field("show_plus", 32'(want.flags[fsp_pkg::FB_PLUS]),
                                32'(o_m_tdata[12]));
                    check_field("alt_form", 32'(want.flags[fsp_pkg::FB_HASH]),
                                32'(o_m_tdata[13]));
                    check_field("zero_pad", 32'(want.flags[fsp_pkg::FB_ZERO]),
                                32'(o_m_tdata[14]));
                    check_field("space_sign", 32'(want.flags[fsp_pkg::FB_SPACE]),
                                32'(o_m_tdata[15]));
                    check_field("field_width", 32'(want.width), 32'(o_m_tdata[46:16]));
                    check_field("prec_value", want.prec, o_m_tdata[78:47]);
                    check_field("length_mod", 32'(want.lmod), 32'(o_m_tdata[81:79]));
                    check_field("num_overflow", 32'(want.ovf), 32'(o_m_tdata[82]));
                    check_field("pad", 32'h0, 32'(o_m_tdata[87:83]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parser();

        // all flags at once: plus drops space, minus drops zero, apostrophe ignored
        add_char(fsp_pkg::CH_MINUS); add_char(fsp_pkg::CH_PLUS); add_char(fsp_pkg::CH_HASH);
        add_char(fsp_pkg::CH_0); add_char(fsp_pkg::CH_SPACE); add_char(fsp_pkg::CH_APOS);
        add_char(fsp_pkg::CH_LO_D);
        // most negative star width saturates; negative star precision; f default
        add_star(32'h8000_0000); add_char(fsp_pkg::CH_DOT); add_star(32'hFFFF_FFFB);
        add_char(fsp_pkg::CH_LO_F);
        // largest positive stars
        add_star(32'h7FFF_FFFF); add_char(fsp_pkg::CH_DOT); add_star(32'h7FFF_FFFF);
        add_char(fsp_pkg::CH_LO_X);
        // literal percent, end of string
        add_char(fsp_pkg::CH_PCT); add_char(fsp_pkg::CH_NUL);
        // empty precision with hh, closed by an unknown letter
        add_char(fsp_pkg::CH_0 + 8'd3); add_char(fsp_pkg::CH_DOT);
        add_char(fsp_pkg::CH_LO_H); add_char(fsp_pkg::CH_LO_H);
        add_char(fsp_pkg::CH_UP_Z);
        // l then L, closed by an unknown letter
        add_char(fsp_pkg::CH_LO_L); add_char(fsp_pkg::CH_UP_L);
        add_char(fsp_pkg::CH_LO_Z - 8'd1);
        // star after width digits is misplaced and closes the spec
        add_char(fsp_pkg::CH_0); add_char(fsp_pkg::CH_MINUS); add_char(fsp_pkg::CH_9);
        add_star(32'h7FFF_FFFF);

        add_random_spec(1'b1);
        while (char_queue.size() < RANDOM_CHARS)
            add_random_spec(1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain stimulus, then outstanding results, then a short tail
        while (char_queue.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (due_specs.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d characters parsed into %0d results", chars_sent, specs_seen);
        $display("tb: spec %0d, percent %0d, end %0d, unknown %0d, other %0d",
                 outcome_count[fsp_pkg::OUT_SPEC], outcome_count[fsp_pkg::OUT_PERCENT],
                 outcome_count[fsp_pkg::OUT_END], outcome_count[fsp_pkg::OUT_UNKNOWN],
                 outcome_count[fsp_pkg::OUT_OTHER]);
        if (errors == 0 && due_specs.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

[format_spec_parser.f]
hdl/fsp_pkg.sv
hdl/format_spec_parser.sv
tb/tb.sv
